// ----- rtl/core/tcpl_pkg.sv -----
// shared constants, codes and transaction types for the two-class priority list
package tcpl_pkg;

  // list geometry
  localparam int Depth   = 16;
  localparam int IdWidth = 16;
  localparam int PosWidth = 4;
  localparam int AddrWidth  = $clog2(Depth);
  localparam int CountWidth = $clog2(Depth + 1);

  // command codes
  localparam logic [1:0] CMD_ADD_NORMAL = 2'd0;
  localparam logic [1:0] CMD_ADD_HIGH   = 2'd1;
  localparam logic [1:0] CMD_REMOVE     = 2'd2;
  localparam logic [1:0] CMD_READ       = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;
  localparam logic [2:0] ST_RANGE   = 3'd5;

  // one command transaction
  typedef struct packed {
    logic [1:0]          command;
    logic [IdWidth-1:0]  entry_id;
    logic [PosWidth-1:0] position;
  } req_t;

  // one result transaction
  typedef struct packed {
    logic [2:0]            status;
    logic [IdWidth-1:0]    read_id;
    logic [CountWidth-1:0] entry_count;
    logic [CountWidth-1:0] high_count;
  } rsp_t;

endpackage

// ----- rtl/core/tcpl_engine.sv -----
// list storage with a sequencer that shifts, scans, compacts and reads one entry per step
module tcpl_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tcpl_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output tcpl_pkg::rsp_t rsp,
  input  logic          rsp_take
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SHIFT_RD = 4'd1;
  localparam logic [3:0] S_SHIFT_WR = 4'd2;
  localparam logic [3:0] S_INSERT   = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_CMP = 4'd5;
  localparam logic [3:0] S_PACK_RD  = 4'd6;
  localparam logic [3:0] S_PACK_WR  = 4'd7;
  localparam logic [3:0] S_READ_RD  = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;

  logic [3:0]                         state;
  logic [1:0]                         cmd;
  logic [tcpl_pkg::IdWidth-1:0]       id;
  logic [tcpl_pkg::PosWidth-1:0]      pos;
  logic [tcpl_pkg::CountWidth-1:0]    idx;
  logic [tcpl_pkg::CountWidth-1:0]    total;
  logic [tcpl_pkg::CountWidth-1:0]    high_total;
  logic [2:0]                         status;
  logic [tcpl_pkg::IdWidth-1:0]       mem [tcpl_pkg::Depth];
  logic [tcpl_pkg::IdWidth-1:0]       rdata;

  logic [tcpl_pkg::CountWidth-1:0]    slot;
  logic [tcpl_pkg::CountWidth-1:0]    idx_m1;
  logic [tcpl_pkg::CountWidth-1:0]    idx_p1;
  logic                               rd_en;
  logic [tcpl_pkg::AddrWidth-1:0]     raddr;
  logic                               we;
  logic [tcpl_pkg::AddrWidth-1:0]     waddr;
  logic [tcpl_pkg::IdWidth-1:0]       wdata;

  // insertion point: head of the list for high class, head of normal class otherwise
  assign slot   = (cmd == tcpl_pkg::CMD_ADD_HIGH) ? '0 : high_total;
  assign idx_m1 = idx - tcpl_pkg::CountWidth'(1);
  assign idx_p1 = idx + tcpl_pkg::CountWidth'(1);

  // memory port control
  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    unique case (state)
      S_SHIFT_RD: begin
        rd_en = (idx != slot);
        raddr = idx_m1[tcpl_pkg::AddrWidth-1:0];
      end
      S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = idx[tcpl_pkg::AddrWidth-1:0];
      end
      S_INSERT: begin
        we    = 1'b1;
        waddr = slot[tcpl_pkg::AddrWidth-1:0];
        wdata = id;
      end
      S_SCAN_RD: begin
        rd_en = 1'b1;
        raddr = idx[tcpl_pkg::AddrWidth-1:0];
      end
      S_PACK_RD: begin
        rd_en = (idx < total);
        raddr = idx_p1[tcpl_pkg::AddrWidth-1:0];
      end
      S_PACK_WR: begin
        we    = 1'b1;
        waddr = idx[tcpl_pkg::AddrWidth-1:0];
      end
      S_READ_RD: begin
        rd_en = 1'b1;
        raddr = tcpl_pkg::AddrWidth'(pos);
      end
      default: ;
    endcase
  end

  // entry storage, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      total      <= '0;
      high_total <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd <= req.command;
            id  <= req.entry_id;
            pos <= req.position;
            idx <= '0;
            status <= tcpl_pkg::ST_OK;
            priority if (req.command == tcpl_pkg::CMD_ADD_NORMAL ||
                         req.command == tcpl_pkg::CMD_ADD_HIGH) begin
              priority if (req.entry_id == '0) begin
                status <= tcpl_pkg::ST_NULL;
                state  <= S_FINISH;
              end else if (total >= tcpl_pkg::CountWidth'(tcpl_pkg::Depth)) begin
                status <= tcpl_pkg::ST_FULL;
                state  <= S_FINISH;
              end else begin
                idx   <= total;
                state <= S_SHIFT_RD;
              end
            end else if (req.command == tcpl_pkg::CMD_REMOVE) begin
              priority if (req.entry_id == '0) begin
                status <= tcpl_pkg::ST_NULL;
                state  <= S_FINISH;
              end else if (total == '0) begin
                status <= tcpl_pkg::ST_EMPTY;
                state  <= S_FINISH;
              end else begin
                state <= S_SCAN_RD;
              end
            end else begin
              if (tcpl_pkg::CountWidth'(req.position) >= total) begin
                status <= tcpl_pkg::ST_RANGE;
                state  <= S_FINISH;
              end else begin
                state <= S_READ_RD;
              end
            end
          end
        end
        // move entries back one slot until the insertion point is open
        S_SHIFT_RD: begin
          state <= (idx == slot) ? S_INSERT : S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx   <= idx_m1;
          state <= S_SHIFT_RD;
        end
        S_INSERT: begin
          total <= total + tcpl_pkg::CountWidth'(1);
          if (cmd == tcpl_pkg::CMD_ADD_HIGH) begin
            high_total <= high_total + tcpl_pkg::CountWidth'(1);
          end
          state <= S_FINISH;
        end
        // search for the first match from the front
        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          priority if (rdata == id) begin
            total <= total - tcpl_pkg::CountWidth'(1);
            if (idx < high_total) begin
              high_total <= high_total - tcpl_pkg::CountWidth'(1);
            end
            state <= S_PACK_RD;
          end else if (idx_p1 >= total) begin
            status <= tcpl_pkg::ST_MISSING;
            state  <= S_FINISH;
          end else begin
            idx   <= idx_p1;
            state <= S_SCAN_RD;
          end
        end
        // close the gap left by the removed entry
        S_PACK_RD: begin
          state <= (idx < total) ? S_PACK_WR : S_FINISH;
        end
        S_PACK_WR: begin
          idx   <= idx_p1;
          state <= S_PACK_RD;
        end
        S_READ_RD: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (rsp_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result fields
  assign busy = (state != S_IDLE);
  assign done = (state == S_FINISH);
  assign rsp.status      = status;
  assign rsp.read_id     = (cmd == tcpl_pkg::CMD_READ && status == tcpl_pkg::ST_OK) ?
                           rdata : '0;
  assign rsp.entry_count = total;
  assign rsp.high_count  = high_total;

`ifndef SYNTHESIS
  a_high_within_total: assert property (@(posedge clk) disable iff (rst)
    high_total <= total)
    else $error("high class count exceeds entry count");

  a_total_within_depth: assert property (@(posedge clk) disable iff (rst)
    total <= tcpl_pkg::CountWidth'(tcpl_pkg::Depth))
    else $error("entry count exceeds depth");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> (state != S_IDLE))
    else $error("accepted command did not start the sequencer");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |=> (total == $past(total) + tcpl_pkg::CountWidth'(1)))
    else $error("insert did not grow the list by one");
`endif

endmodule

// ----- rtl/core/two_class_priority_list.sv -----
// top level of the two-class priority list: command intake and result register
//
//  channel | valid / stall        | fields
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | command, entry_id, position
//  out     | out_valid / out_stall| status, read_id, entry_count, high_count
//
// one command at a time through an entry memory with a registered read
// an add moves each entry behind the insertion point back one slot, then writes the new id;
// a remove scans from the front for the first match, then closes the gap behind it;
// a read fetches one entry by position; rejected commands go straight to the result
// in_stall drops in the same cycle that out_valid rises; reset clears the counts;
// stored entries need no clearing pass
// a finished result waits in the sequencer while the result register is full and stalled
module two_class_priority_list (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       command,
  input  logic [tcpl_pkg::IdWidth-1:0]     entry_id,
  input  logic [tcpl_pkg::PosWidth-1:0]    position,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       status,
  output logic [tcpl_pkg::IdWidth-1:0]     read_id,
  output logic [tcpl_pkg::CountWidth-1:0]  entry_count,
  output logic [tcpl_pkg::CountWidth-1:0]  high_count
);

  tcpl_pkg::req_t req;
  tcpl_pkg::rsp_t rsp;
  logic           busy;
  logic           done;
  logic           rsp_take;
  logic           start;

  // command intake
  assign req.command  = command;
  assign req.entry_id = entry_id;
  assign req.position = position;
  assign in_stall     = busy;
  assign start        = in_valid && !busy;

  // result register can load when empty or being drained
  assign rsp_take = !out_valid || !out_stall;

  tcpl_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .done     (done),
    .rsp      (rsp),
    .rsp_take (rsp_take)
  );

  // output transaction register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_take) begin
      out_valid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done && rsp_take) begin
      status      <= rsp.status;
      read_id     <= rsp.read_id;
      entry_count <= rsp.entry_count;
      high_count  <= rsp.high_count;
    end
  end

endmodule

// ----- tb/sv/two_class_priority_list_tb.sv -----
// testbench for the two-class priority list: queued stimulus, list predictor, result checker
module two_class_priority_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit  = 5000;
  localparam int DrainCycles = 60;
  localparam int HoldCycles  = 300;
  localparam int HoldAfter   = 400;
  localparam int RandomItems = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [1:0]                      command = tcpl_pkg::CMD_READ;
  logic [tcpl_pkg::IdWidth-1:0]    entry_id = '0;
  logic [tcpl_pkg::PosWidth-1:0]   position = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [2:0]                      status;
  logic [tcpl_pkg::IdWidth-1:0]    read_id;
  logic [tcpl_pkg::CountWidth-1:0] entry_count;
  logic [tcpl_pkg::CountWidth-1:0] high_count;

  two_class_priority_list dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .entry_id    (entry_id),
    .position    (position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_id     (read_id),
    .entry_count (entry_count),
    .high_count  (high_count)
  );

  always #1 clk = ~clk;

  // stimulus backlog and predicted results
  tcpl_pkg::req_t               cmd_backlog[$];
  tcpl_pkg::rsp_t               list_outcomes[$];
  logic [tcpl_pkg::IdWidth-1:0] id_pool[8];
  logic [tcpl_pkg::IdWidth-1:0] stray_ids[$];

  // shadow copy of the list
  logic [tcpl_pkg::IdWidth-1:0]    shadow_ids[tcpl_pkg::Depth];
  logic [tcpl_pkg::CountWidth-1:0] shadow_len  = '0;
  logic [tcpl_pkg::CountWidth-1:0] shadow_high = '0;

  int error_count   = 0;
  int results_taken = 0;
  int idle_cycles   = 0;

  // apply one command to the shadow list and return the result it must produce
  function automatic tcpl_pkg::rsp_t apply_list_command(tcpl_pkg::req_t req);
    tcpl_pkg::rsp_t r;
    int   at;
    int   hit;
    r = '0;
    r.status = tcpl_pkg::ST_OK;
    case (req.command)
      tcpl_pkg::CMD_ADD_NORMAL, tcpl_pkg::CMD_ADD_HIGH: begin
        if (req.entry_id == '0) begin
          r.status = tcpl_pkg::ST_NULL;
        end else if (shadow_len >= tcpl_pkg::Depth) begin
          r.status = tcpl_pkg::ST_FULL;
        end else begin
          // high adds go to the very front, normal adds right behind the high class
          at = (req.command == tcpl_pkg::CMD_ADD_HIGH) ? 0 : int'(shadow_high);
          for (int i = int'(shadow_len); i > at; i--) shadow_ids[i] = shadow_ids[i-1];
          shadow_ids[at] = req.entry_id;
          shadow_len = shadow_len + 1'b1;
          if (req.command == tcpl_pkg::CMD_ADD_HIGH) shadow_high = shadow_high + 1'b1;
        end
      end
      tcpl_pkg::CMD_REMOVE: begin
        if (req.entry_id == '0) begin
          r.status = tcpl_pkg::ST_NULL;
        end else if (shadow_len == '0) begin
          r.status = tcpl_pkg::ST_EMPTY;
        end else begin
          // only the first match goes away
          hit = int'(shadow_len);
          for (int i = 0; i < int'(shadow_len); i++) begin
            if (shadow_ids[i] == req.entry_id && hit == int'(shadow_len)) hit = i;
          end
          if (hit >= int'(shadow_len)) begin
            r.status = tcpl_pkg::ST_MISSING;
          end else begin
            for (int i = hit; i + 1 < int'(shadow_len); i++) shadow_ids[i] = shadow_ids[i+1];
            shadow_len = shadow_len - 1'b1;
            if (hit < int'(shadow_high)) shadow_high = shadow_high - 1'b1;
          end
        end
      end
      default: begin
        if (req.position >= shadow_len) r.status = tcpl_pkg::ST_RANGE;
        else r.read_id = shadow_ids[req.position];
      end
    endcase
    r.entry_count = shadow_len;
    r.high_count  = shadow_high;
    return r;
  endfunction

  task automatic queue_cmd(logic [1:0] c, logic [tcpl_pkg::IdWidth-1:0] id,
                           logic [tcpl_pkg::PosWidth-1:0] p);
    tcpl_pkg::req_t req;
    req.command  = c;
    req.entry_id = id;
    req.position = p;
    cmd_backlog.push_back(req);
  endtask

  // bias 0 fills the list, 1 drains it, 2 mixes
  task automatic queue_random_phase(int bias, int n);
    int                            roll;
    int                            add_pct;
    int                            rem_pct;
    int                            idx;
    logic [1:0]                    c;
    logic [tcpl_pkg::IdWidth-1:0]  id;
    logic [tcpl_pkg::PosWidth-1:0] p;
    add_pct = (bias == 0) ? 70 : (bias == 1) ? 15 : 40;
    rem_pct = (bias == 0) ? 15 : (bias == 1) ? 65 : 35;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      p    = tcpl_pkg::PosWidth'($urandom_range(0, 15));
      id   = id_pool[$urandom_range(0, 7)];
      if (roll < add_pct) begin
        c    = $urandom_range(0, 1) ? tcpl_pkg::CMD_ADD_HIGH : tcpl_pkg::CMD_ADD_NORMAL;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          id = '0;
        end else if (roll < 10) begin
          id = tcpl_pkg::IdWidth'($urandom_range(1, 16'hFFFF));
          stray_ids.push_back(id);
        end
      end else if (roll < add_pct + rem_pct) begin
        c    = tcpl_pkg::CMD_REMOVE;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          id = '0;
        end else if (roll < 10) begin
          id = tcpl_pkg::IdWidth'($urandom);
        end else if (roll < 25 && stray_ids.size() > 0) begin
          // pull strays back out so they do not clog the list
          idx = $urandom_range(0, stray_ids.size() - 1);
          id  = stray_ids[idx];
          stray_ids.delete(idx);
        end
      end else begin
        c  = tcpl_pkg::CMD_READ;
        id = tcpl_pkg::IdWidth'($urandom);
      end
      queue_cmd(c, id, p);
    end
  endtask

  // stimulus: directed corners, then random phases; reset and end of run
  initial begin
    int queued;
    int n;
    // empty list corners and null ids
    queue_cmd(tcpl_pkg::CMD_READ,       16'h0000, 4'd0);
    queue_cmd(tcpl_pkg::CMD_REMOVE,     16'h1234, 4'd0);
    queue_cmd(tcpl_pkg::CMD_ADD_NORMAL, 16'h0000, 4'd0);
    queue_cmd(tcpl_pkg::CMD_REMOVE,     16'h0000, 4'd0);
    // both classes, id extremes, a duplicate
    queue_cmd(tcpl_pkg::CMD_ADD_HIGH,   16'h0001, 4'd0);
    queue_cmd(tcpl_pkg::CMD_ADD_NORMAL, 16'hFFFF, 4'd0);
    queue_cmd(tcpl_pkg::CMD_ADD_HIGH,   16'h0001, 4'd0);
    // fill to capacity
    for (int k = 0; k < 13; k++) begin
      queue_cmd((k % 3 == 0) ? tcpl_pkg::CMD_ADD_HIGH : tcpl_pkg::CMD_ADD_NORMAL,
                tcpl_pkg::IdWidth'(16'h0A00 + k), 4'd0);
    end
    queue_cmd(tcpl_pkg::CMD_ADD_NORMAL, 16'hAAAA, 4'd0);
    queue_cmd(tcpl_pkg::CMD_ADD_HIGH,   16'h5555, 4'd0);
    queue_cmd(tcpl_pkg::CMD_ADD_HIGH,   16'h0000, 4'd0);
    queue_cmd(tcpl_pkg::CMD_READ,       16'hFFFF, 4'd15);
    queue_cmd(tcpl_pkg::CMD_READ,       16'h0000, 4'd0);
    // first match in the high class, a missing id, a normal-class match
    queue_cmd(tcpl_pkg::CMD_REMOVE,     16'h0001, 4'd0);
    queue_cmd(tcpl_pkg::CMD_REMOVE,     16'h7777, 4'd0);
    queue_cmd(tcpl_pkg::CMD_REMOVE,     16'hFFFF, 4'd0);
    queue_cmd(tcpl_pkg::CMD_READ,       16'h0000, 4'd14);

    foreach (id_pool[i]) id_pool[i] = tcpl_pkg::IdWidth'($urandom_range(1, 16'hFFFF));
    queued = 0;
    while (queued < RandomItems) begin
      n = $urandom_range(30, 120);
      queue_random_phase($urandom_range(0, 2), n);
      queued += n;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || in_valid || list_outcomes.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (list_outcomes.size() != 0) error_count++;

    if (error_count == 0) begin
      $display("two_class_priority_list test passed");
    end else begin
      $display("two_class_priority_list test failed");
    end
    $finish;
  end

  // driver: bursts of transactions separated by random gaps
  int  burst_left = 0;
  int  gap_left   = 0;
  tcpl_pkg::req_t next_req;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        list_outcomes.push_back(apply_list_command({command, entry_id, position}));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          next_req = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          command  <= next_req.command;
          entry_id <= next_req.entry_id;
          position <= next_req.position;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: changing patterns plus one long hold-off
  int  stall_mode  = 0;
  int  mode_cycles = 0;
  int  hold_cycles = 0;
  logic hold_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall   <= (hold_cycles != 1);
    end else if (!hold_done && results_taken >= HoldAfter) begin
      hold_done   <= 1'b1;
      hold_cycles <= HoldCycles;
      out_stall   <= 1'b1;
    end else begin
      if (mode_cycles == 0) begin
        stall_mode  <= $urandom_range(0, 3);
        mode_cycles <= $urandom_range(50, 300);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 70);
        default: out_stall <= ((mode_cycles % 8) < 3);
      endcase
    end
  end

  task automatic flag_mismatch(string what, tcpl_pkg::rsp_t want, tcpl_pkg::rsp_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%s: expected status %0d read_id %h count %0d high %0d,",
               what, want.status, want.read_id, want.entry_count, want.high_count);
      $display("  got status %0d read_id %h count %0d high %0d",
               got.status, got.read_id, got.entry_count, got.high_count);
    end
  endtask

  // monitor: compare each result transaction with the oldest prediction
  tcpl_pkg::rsp_t seen;
  tcpl_pkg::rsp_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_taken <= results_taken + 1;
      seen = {status, read_id, entry_count, high_count};
      if (list_outcomes.size() == 0) begin
        flag_mismatch("result with no command pending", '0, seen);
      end else begin
        want = list_outcomes.pop_front();
        if (seen.status != want.status || seen.read_id != want.read_id ||
            seen.entry_count != want.entry_count || seen.high_count != want.high_count) begin
          flag_mismatch("result mismatch", want, seen);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("two_class_priority_list test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
rtl/core/tcpl_pkg.sv
rtl/core/tcpl_engine.sv
rtl/core/two_class_priority_list.sv
tb/sv/two_class_priority_list_tb.sv
